/* design/selt_pkg.sv */
`timescale 1ns / 1ps
// selt_pkg: types, codes and constants shared by the lock table modules
// no dependencies

package selt_pkg;

  localparam int SELT_ENTRIES = 64;

  localparam logic [1:0] KIND_ACQUIRE = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_HELD    = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CONFLICT = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  localparam logic [15:0] TXN_NONE = 16'd0;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        txn_id;
    logic [7:0]         table_id;
    logic signed [31:0] row_key;
    logic               lock_mode;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       is_held;
  } rsp_t;

  // one stored lock slot
  typedef struct packed {
    logic [15:0]        owner_txn;
    logic [7:0]         entry_table;
    logic signed [31:0] entry_key;
    logic               entry_exclusive;
  } entry_t;

  // flags gathered over one scan of the used slots
  typedef struct packed {
    logic have_own;
    logic own_excl;
    logic other_s;
    logic other_x;
    logic have_free;
    logic held;
  } scan_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

/* design/selt_ram.sv */
`timescale 1ns / 1ps
// selt_ram: generic single-write, single-read ram with registered read data
// no dependencies

module selt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/selt_match.sv */
`timescale 1ns / 1ps
// selt_match: compares each slot read during a scan against the request and
// accumulates holder, free slot and ownership flags; depends on selt_pkg

module selt_match import selt_pkg::*; #(
  parameter int ENTRIES = SELT_ENTRIES
) (
  input  logic                       clk,
  input  logic                       clear,
  input  logic                       valid,
  input  logic [$clog2(ENTRIES)-1:0] addr,
  input  entry_t                     entry,
  input  req_t                       cur,
  output scan_flags_t                flags,
  output logic [$clog2(ENTRIES)-1:0] own_idx,
  output logic [$clog2(ENTRIES)-1:0] free_idx,
  output logic                       release_hit
);

  logic used_slot;
  logic on_object;
  logic mine;

  assign used_slot   = entry.owner_txn != TXN_NONE;
  assign on_object   = used_slot && entry.entry_table == cur.table_id &&
                       entry.entry_key == cur.row_key;
  assign mine        = used_slot && entry.owner_txn == cur.txn_id;
  assign release_hit = valid && mine && cur.kind == KIND_RELEASE;

  always_ff @(posedge clk) begin
    if (clear) begin
      flags <= '0;
    end else if (valid) begin
      if (on_object && mine) begin
        flags.have_own <= 1'b1;
        flags.own_excl <= entry.entry_exclusive;
        flags.held     <= 1'b1;
        own_idx        <= addr;
      end
      if (on_object && !mine) begin
        if (entry.entry_exclusive) begin
          flags.other_x <= 1'b1;
        end else begin
          flags.other_s <= 1'b1;
        end
      end
      // keep the first free slot only
      if (!used_slot && !flags.have_free) begin
        flags.have_free <= 1'b1;
        free_idx        <= addr;
      end
    end
  end

endmodule

/* design/shared_exclusive_lock_table_core.sv */
`timescale 1ns / 1ps
// shared_exclusive_lock_table_core: lock table with shared/exclusive modes
// the scan reads one slot per cycle from the entry ram, over the used slots only; one request is in
// flight at a time, and a new request is taken while the previous response still waits. reset
// clears the fill count and control and holds req_ready low; slots beyond the fill count are never
// read, so the ram needs no clearing pass. depends on selt_pkg.

module shared_exclusive_lock_table_core import selt_pkg::*; #(
  parameter int ENTRIES = SELT_ENTRIES
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  state_t        state;
  state_t        state_next;
  req_t          cur;
  logic [CW-1:0] slots_used;
  logic [CW-1:0] idx;
  logic          rd_pend;
  logic [AW-1:0] rd_addr_q;

  logic          scan_issue;
  logic          scan_done;
  logic          fin_go;

  entry_t        rd_entry;
  logic [$bits(entry_t)-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_entry;

  scan_flags_t   flags;
  logic [AW-1:0] own_idx;
  logic [AW-1:0] free_idx;
  logic          release_hit;

  logic          fin_wr;
  logic [AW-1:0] fin_addr;
  logic          fin_excl;
  logic          fin_append;
  rsp_t          fin_rsp;

  assign rd_entry = entry_t'(rd_data);

  selt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_en  (scan_issue),
    .rd_addr(idx[AW-1:0]),
    .rd_data(rd_data)
  );

  selt_match #(
    .ENTRIES(ENTRIES)
  ) u_match (
    .clk        (clk),
    .clear      (req_valid && req_ready),
    .valid      (rd_pend),
    .addr       (rd_addr_q),
    .entry      (rd_entry),
    .cur        (cur),
    .flags      (flags),
    .own_idx    (own_idx),
    .free_idx   (free_idx),
    .release_hit(release_hit)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req_ready  = 1'b0;
    scan_issue = 1'b0;
    scan_done  = 1'b0;
    fin_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = !rst;
      end
      ST_SCAN: begin
        scan_issue = idx < slots_used;
        scan_done  = idx == slots_used && !rd_pend;
      end
      ST_FINISH: begin
        fin_go = !rsp_valid || rsp_ready;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  // decision once the scan has finished
  always_comb begin
    fin_rsp    = '0;
    fin_wr     = 1'b0;
    fin_addr   = own_idx;
    fin_excl   = cur.lock_mode;
    fin_append = 1'b0;
    priority case (cur.kind)
      KIND_ACQUIRE: begin
        if (cur.txn_id == TXN_NONE) begin
          fin_rsp.status = STATUS_CONFLICT;
        end else if (flags.have_own) begin
          if (!cur.lock_mode || flags.own_excl) begin
            fin_rsp.status = STATUS_OK;
          end else if (flags.other_s || flags.other_x) begin
            fin_rsp.status = STATUS_CONFLICT;
          end else begin
            // upgrade in place
            fin_wr   = 1'b1;
            fin_excl = 1'b1;
          end
        end else if ((cur.lock_mode && (flags.other_s || flags.other_x)) ||
                     (!cur.lock_mode && flags.other_x)) begin
          fin_rsp.status = STATUS_CONFLICT;
        end else if (flags.have_free) begin
          fin_wr   = 1'b1;
          fin_addr = free_idx;
        end else if (slots_used == CW'(ENTRIES)) begin
          fin_rsp.status = STATUS_FULL;
        end else begin
          fin_wr     = 1'b1;
          fin_append = 1'b1;
          fin_addr   = slots_used[AW-1:0];
        end
      end
      KIND_HELD: begin
        fin_rsp.is_held = flags.held;
      end
      default: begin
        fin_rsp = '0;
      end
    endcase
  end

  // write port: release clears owners during the scan, acquire writes at the end
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = rd_addr_q;
    wr_entry = rd_entry;
    if (state == ST_SCAN && release_hit) begin
      wr_en              = 1'b1;
      wr_entry.owner_txn = TXN_NONE;
    end else if (fin_go && fin_wr) begin
      wr_en                    = 1'b1;
      wr_addr                  = fin_addr;
      wr_entry.owner_txn       = cur.txn_id;
      wr_entry.entry_table     = cur.table_id;
      wr_entry.entry_key       = cur.row_key;
      wr_entry.entry_exclusive = fin_excl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slots_used <= '0;
      rd_pend    <= 1'b0;
      rsp_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= scan_issue;
      if (req_valid && req_ready) begin
        idx <= '0;
      end else if (scan_issue) begin
        idx <= idx + CW'(1);
      end
      if (fin_go && fin_append) begin
        slots_used <= slots_used + CW'(1);
      end
      if (fin_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= idx[AW-1:0];
    if (req_valid && req_ready) begin
      cur <= req;
    end
    if (fin_go) begin
      rsp <= fin_rsp;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CW'(ENTRIES))
    else $error("fill count beyond table size");

  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == ST_SCAN)
    else $error("accepted request did not start a scan");

  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    wr_en && state == ST_SCAN |-> cur.kind == KIND_RELEASE && rd_pend)
    else $error("ram write during scan outside release");

  a_no_append_full: assert property (@(posedge clk) disable iff (rst)
    fin_go && fin_append |-> slots_used < CW'(ENTRIES) && !flags.have_free)
    else $error("append with free slot or full table");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// tb: self-checking bench for shared_exclusive_lock_table_core, directed table then random mixes
// keeps its own copy of the lock slots to predict each response; depends on selt_pkg

module tb;
  import selt_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic MODE_SHARED = 1'b0;
  localparam logic MODE_EXCL   = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam logic TYPED     = 1'b1;
  localparam int HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 500_000;

  typedef enum {MIX_CONTENTION, MIX_FILL, MIX_WIDE} mix_t;

  typedef struct packed {
    req_t r;
    logic typed;
    rsp_t want;
  } dir_row_t;

  typedef struct packed {
    req_t r;
    rsp_t want;
  } lock_exp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  bit idle_on = 1'b1;
  bit hold_off_pending = 1'b0;
  int mismatch_count = 0;
  int unsigned cycle_count = 0;

  // predictor copy of the lock slots
  entry_t lk_slot [SELT_ENTRIES];
  int lk_used = 0;
  lock_exp_t awaited_rsp [$];

  // objects of recent acquires, reused so random requests collide
  logic [7:0]  recent_table [8];
  logic [31:0] recent_key [8];
  int recent_wr = 0;

  shared_exclusive_lock_table_core dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic rsp_t predict_lock(req_t r);
    rsp_t o;
    int own;
    int free_slot;
    bit have_own;
    bit other_s;
    bit other_x;
    o = '0;
    own = 0;
    free_slot = -1;
    have_own = 1'b0;
    other_s = 1'b0;
    other_x = 1'b0;
    if (r.txn_id == TXN_NONE) begin
      if (r.kind == KIND_ACQUIRE) o.status = STATUS_CONFLICT;
      return o;
    end
    case (r.kind)
      KIND_ACQUIRE: begin
        for (int i = 0; i < lk_used; i++) begin
          if (lk_slot[i].owner_txn != TXN_NONE && lk_slot[i].entry_table == r.table_id &&
              lk_slot[i].entry_key == r.row_key) begin
            if (lk_slot[i].owner_txn == r.txn_id) begin
              own = i;
              have_own = 1'b1;
            end else if (lk_slot[i].entry_exclusive) begin
              other_x = 1'b1;
            end else begin
              other_s = 1'b1;
            end
          end
          if (lk_slot[i].owner_txn == TXN_NONE && free_slot < 0) free_slot = i;
        end
        if (have_own) begin
          // upgrade only when nobody else holds the object
          if (r.lock_mode == MODE_EXCL && !lk_slot[own].entry_exclusive) begin
            if (other_s || other_x) o.status = STATUS_CONFLICT;
            else lk_slot[own].entry_exclusive = 1'b1;
          end
        end else if (other_x || (r.lock_mode == MODE_EXCL && other_s)) begin
          o.status = STATUS_CONFLICT;
        end else begin
          if (free_slot < 0 && lk_used < SELT_ENTRIES) begin
            free_slot = lk_used;
            lk_used++;
          end
          if (free_slot < 0) begin
            o.status = STATUS_FULL;
          end else begin
            lk_slot[free_slot].owner_txn = r.txn_id;
            lk_slot[free_slot].entry_table = r.table_id;
            lk_slot[free_slot].entry_key = r.row_key;
            lk_slot[free_slot].entry_exclusive = r.lock_mode;
          end
        end
      end
      KIND_RELEASE: begin
        for (int i = 0; i < lk_used; i++)
          if (lk_slot[i].owner_txn == r.txn_id) lk_slot[i].owner_txn = TXN_NONE;
      end
      KIND_HELD: begin
        for (int i = 0; i < lk_used; i++)
          if (lk_slot[i].owner_txn == r.txn_id && lk_slot[i].entry_table == r.table_id &&
              lk_slot[i].entry_key == r.row_key) o.is_held = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic dir_row_t dir_row(logic [1:0] kind, logic [15:0] txn, logic [7:0] tbl,
                                       logic [31:0] key, logic mode, logic typed,
                                       logic [1:0] status, logic held);
    dir_row_t d;
    d.r.kind = kind;
    d.r.txn_id = txn;
    d.r.table_id = tbl;
    d.r.row_key = key;
    d.r.lock_mode = mode;
    d.typed = typed;
    d.want.status = status;
    d.want.is_held = held;
    return d;
  endfunction

  function automatic req_t gen_request(mix_t mix);
    req_t r;
    int unsigned pick;
    int unsigned k;
    r.lock_mode = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (mix == MIX_FILL) begin
      if (pick < 85) r.kind = KIND_ACQUIRE;
      else if (pick < 95) r.kind = KIND_HELD;
      else r.kind = KIND_RELEASE;
    end else begin
      if (pick < 55) r.kind = KIND_ACQUIRE;
      else if (pick < 80) r.kind = KIND_HELD;
      else r.kind = KIND_RELEASE;
    end
    case (mix)
      MIX_CONTENTION: r.txn_id = 16'($urandom_range(1, 6));
      MIX_FILL:       r.txn_id = 16'($urandom_range(1, 24));
      default:        r.txn_id = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                                                                16'($urandom_range(1, 6));
    endcase
    if (mix == MIX_CONTENTION) begin
      case ($urandom_range(0, 2))
        0: r.table_id = 8'h00;
        1: r.table_id = 8'h01;
        default: r.table_id = 8'hFF;
      endcase
      case ($urandom_range(0, 4))
        0: r.row_key = 32'h8000_0000;
        1: r.row_key = 32'h7FFF_FFFF;
        2: r.row_key = 32'h0000_0000;
        3: r.row_key = 32'hFFFF_FFFF;
        default: r.row_key = 32'd5;
      endcase
    end else if ($urandom_range(0, 1) == 0) begin
      k = $urandom_range(0, 7);
      r.table_id = recent_table[k];
      r.row_key = recent_key[k];
    end else begin
      r.table_id = 8'($urandom());
      r.row_key = $urandom();
      if (r.kind == KIND_ACQUIRE) begin
        recent_table[recent_wr] = r.table_id;
        recent_key[recent_wr] = r.row_key;
        recent_wr = (recent_wr + 1) % 8;
      end
    end
    // a little noise: unused kind or invalid transaction
    if (pick >= 97) begin
      r.kind = 2'($urandom_range(0, 3));
      if (r.kind != KIND_UNUSED) r.txn_id = TXN_NONE;
    end
    return r;
  endfunction

  task automatic issue_request(req_t r, logic typed, rsp_t typed_rsp);
    lock_exp_t e;
    rsp_t p;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    p = predict_lock(r);
    e.r = r;
    e.want = typed ? typed_rsp : p;
    awaited_rsp.push_back(e);
  endtask

  task automatic run_mix(mix_t mix, int count);
    req_t r;
    int n;
    n = 0;
    while (n < count) begin
      r = gen_request(mix);
      issue_request(r, PREDICTED, '0);
      if (r.kind != KIND_UNUSED) n++;
    end
  endtask

  // response side: random stalls plus one long hold-off
  initial begin
    while (rst) @(posedge clk);
    rsp_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    lock_exp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (awaited_rsp.size() == 0) begin
        flag_mismatch("response with no request outstanding");
      end else begin
        e = awaited_rsp.pop_front();
        if (rsp.status !== e.want.status)
          flag_mismatch($sformatf("status %0d, want %0d (kind %0d txn %h tbl %h key %h mode %0d)",
                                  rsp.status, e.want.status, e.r.kind, e.r.txn_id,
                                  e.r.table_id, e.r.row_key, e.r.lock_mode));
        if (rsp.is_held !== e.want.is_held)
          flag_mismatch($sformatf("is_held %0d, want %0d (kind %0d txn %h tbl %h key %h)",
                                  rsp.is_held, e.want.is_held, e.r.kind, e.r.txn_id,
                                  e.r.table_id, e.r.row_key));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL shared_exclusive_lock_table_core");
    $finish;
  end

  initial begin
    dir_row_t rows [$];
    for (int i = 0; i < SELT_ENTRIES; i++) lk_slot[i] = '0;
    for (int i = 0; i < 8; i++) begin
      recent_table[i] = '0;
      recent_key[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    //                kind          txn       tbl    key           mode
    rows.push_back(dir_row(KIND_HELD,    16'd5,    8'h00, 32'h0,        MODE_SHARED,
                           TYPED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_RELEASE, TXN_NONE, 8'h00, 32'h0,        MODE_SHARED,
                           TYPED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_ACQUIRE, TXN_NONE, 8'h00, 32'h0,        MODE_EXCL,
                           TYPED, STATUS_CONFLICT, 1'b0));
    rows.push_back(dir_row(KIND_HELD,    TXN_NONE, 8'h00, 32'h0,        MODE_SHARED,
                           TYPED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_UNUSED,  16'hFFFF, 8'hFF, 32'h7FFFFFFF, MODE_EXCL,
                           TYPED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_ACQUIRE, 16'd1,    8'h00, 32'h80000000, MODE_SHARED,
                           TYPED, STATUS_OK, 1'b0));
    // second shared holder, then refused upgrade
    rows.push_back(dir_row(KIND_ACQUIRE, 16'd2,    8'h00, 32'h80000000, MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_ACQUIRE, 16'd1,    8'h00, 32'h80000000, MODE_EXCL,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_HELD,    16'd1,    8'h00, 32'h80000000, MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_RELEASE, 16'd2,    8'h00, 32'h0,        MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));
    // sole holder now upgrades
    rows.push_back(dir_row(KIND_ACQUIRE, 16'd1,    8'h00, 32'h80000000, MODE_EXCL,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_ACQUIRE, 16'd1,    8'h00, 32'h80000000, MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_ACQUIRE, 16'd2,    8'h00, 32'h80000000, MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_ACQUIRE, 16'd3,    8'h00, 32'h80000000, MODE_EXCL,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_ACQUIRE, 16'hFFFF, 8'hFF, 32'h7FFFFFFF, MODE_EXCL,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_ACQUIRE, 16'hFFFF, 8'hFF, 32'h7FFFFFFF, MODE_EXCL,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_HELD,    16'hFFFF, 8'hFF, 32'h7FFFFFFF, MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_HELD,    16'hFFFF, 8'hFF, 32'h7FFFFFFE, MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));
    // freed slot gets reused by the next new lock
    rows.push_back(dir_row(KIND_RELEASE, 16'd1,    8'h00, 32'h0,        MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_ACQUIRE, 16'd4,    8'h55, 32'h0,        MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_HELD,    16'd1,    8'h00, 32'h80000000, MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_RELEASE, 16'd9,    8'h00, 32'h0,        MODE_SHARED,
                           TYPED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_UNUSED,  TXN_NONE, 8'h00, 32'h0,        MODE_SHARED,
                           TYPED, STATUS_OK, 1'b0));
    rows.push_back(dir_row(KIND_ACQUIRE, 16'h8000, 8'hAA, 32'hFFFFFFFF, MODE_SHARED,
                           PREDICTED, STATUS_OK, 1'b0));

    foreach (rows[i]) issue_request(rows[i].r, rows[i].typed, rows[i].want);

    hold_off_pending = 1'b1;
    run_mix(MIX_CONTENTION, 300);
    run_mix(MIX_FILL, 250);
    run_mix(MIX_WIDE, 250);
    idle_on = 1'b0;
    run_mix(MIX_CONTENTION, 150);
    req_valid <= 1'b0;

    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (SELT_ENTRIES + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS shared_exclusive_lock_table_core");
    end else begin
      $display("FAIL shared_exclusive_lock_table_core");
    end
    $finish;
  end

endmodule
